@@ hdl/rzs_pkg.sv @@
// package for the rolling z-score spread classifier
// word layouts, class codes and fixed field widths; no dependencies
package rzs_pkg;

  localparam int PRICE_W  = 24;
  localparam int SPREAD_W = 25;
  localparam int SQ_W     = 48;
  localparam int CNT_W    = 32;
  localparam int CLASS_W  = 3;

  typedef enum logic [CLASS_W-1:0] {
    CLS_WARMUP = 3'd0,
    CLS_LONG   = 3'd1,
    CLS_SHORT  = 3'd2,
    CLS_CLOSE  = 3'd3,
    CLS_NONE   = 3'd4
  } sig_class_t;

  typedef struct packed {
    logic signed [SPREAD_W-1:0] spread;
    logic [SQ_W-1:0]            square;
  } spread_word_t;

  typedef struct packed {
    sig_class_t       cls;
    logic [CNT_W-1:0] long_cnt;
    logic [CNT_W-1:0] short_cnt;
    logic [CNT_W-1:0] close_cnt;
    logic [CNT_W-1:0] none_cnt;
  } result_word_t;

endpackage

@@ hdl/rzs_ram.sv @@
// generic single-write, single-read ram with registered read data
// no dependencies
module rzs_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 8
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= mem_r[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

@@ hdl/rzs_fifo.sv @@
// small register queue with push/full and pop/empty sides
// no dependencies
module rzs_fifo #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  logic [WIDTH-1:0] wr_data,
  output logic             full,
  input  logic             pop,
  output logic [WIDTH-1:0] rd_data,
  output logic             empty
);

  localparam int AW = $clog2(DEPTH);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [AW:0]      wp_r, wp_nxt;
  logic [AW:0]      rp_r, rp_nxt;
  logic             do_push, do_pop;

  assign empty   = (wp_r == rp_r);
  assign full    = (wp_r[AW] != rp_r[AW]) && (wp_r[AW-1:0] == rp_r[AW-1:0]);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign wp_nxt  = do_push ? wp_r + 1'b1 : wp_r;
  assign rp_nxt  = do_pop ? rp_r + 1'b1 : rp_r;
  assign rd_data = mem_r[rp_r[AW-1:0]];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r <= '0;
      rp_r <= '0;
    end else begin
      wp_r <= wp_nxt;
      rp_r <= rp_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wp_r[AW-1:0]] <= wr_data;
    end
  end

endmodule

@@ hdl/rzs_front.sv @@
// front end: takes price pairs, forms the spread and its square
// depends on rzs_pkg
module rzs_front
  import rzs_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  input  logic               push,
  output logic               full,
  input  logic [PRICE_W-1:0] price_first,
  input  logic [PRICE_W-1:0] price_second,
  input  logic               q_full,
  output logic               q_push,
  output spread_word_t       q_word
);

  logic                       v1_r, v2_r;
  logic signed [SPREAD_W-1:0] spread_r;
  spread_word_t               word_r;
  logic                       adv1, adv2;
  logic signed [SPREAD_W-1:0] diff;
  logic [PRICE_W-1:0]         mag;

  assign adv2   = !v2_r || !q_full;
  assign adv1   = !v1_r || adv2;
  assign full   = !adv1;
  assign q_push = v2_r && !q_full;
  assign q_word = word_r;

  assign diff = $signed({1'b0, price_first}) - $signed({1'b0, price_second});
  assign mag  = spread_r[SPREAD_W-1] ? PRICE_W'(-spread_r) : PRICE_W'(spread_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
    end else begin
      if (adv1) begin
        v1_r <= push;
      end
      if (adv2) begin
        v2_r <= v1_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv1 && push) begin
      spread_r <= diff;
    end
    if (adv2 && v1_r) begin
      word_r.spread <= spread_r;
      word_r.square <= SQ_W'(mag) * SQ_W'(mag);
    end
  end

endmodule

@@ hdl/rzs_back.sv @@
// back end: window statistics, squaring sequencer, scoring and counters
// depends on rzs_pkg and rzs_ram
module rzs_back
  import rzs_pkg::*;
#(
  parameter int WINDOW = 8
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         q_empty,
  output logic         q_pop,
  input  spread_word_t q_word,
  input  logic         res_full,
  output logic         res_push,
  output result_word_t res_word
);

  localparam int LW    = $clog2(WINDOW);
  localparam int FW    = $clog2(WINDOW + 1);
  localparam int S1_W  = SPREAD_W + LW;
  localparam int S2_W  = SQ_W + LW;
  localparam int D_W   = SPREAD_W + LW + 1;
  localparam int M_W   = SPREAD_W + LW;
  localparam int P_W   = 2 * M_W;
  localparam int NS2_W = SQ_W + 2 * LW;
  localparam int C_W   = P_W + 5;
  localparam logic signed [D_W-1:0] N_D  = D_W'(WINDOW);
  localparam logic [NS2_W-1:0]      N_S2 = NS2_W'(WINDOW);
  localparam logic [FW-1:0]         N_F  = FW'(WINDOW);
  localparam logic [LW-1:0]         WP_LAST = LW'(WINDOW - 1);

  typedef enum logic [3:0] {
    ST_IDLE  = 4'b0001,
    ST_SQ_D  = 4'b0010,
    ST_SQ_S1 = 4'b0100,
    ST_FIN   = 4'b1000
  } back_state_t;

  back_state_t                st_r, st_nxt;
  logic signed [S1_W-1:0]     s1_r, s1_nxt;
  logic [S2_W-1:0]            s2_r, s2_nxt;
  logic [LW-1:0]              wp_r, wp_nxt;
  logic [FW-1:0]              fill_r, fill_nxt;
  logic [CNT_W-1:0]           cnt_r [4];
  logic [CNT_W-1:0]           cnt_nxt [4];

  logic signed [SPREAD_W-1:0] x_r;
  logic [SQ_W-1:0]            xsq_r;
  logic signed [D_W-1:0]      d_r;
  logic [NS2_W-1:0]           ns2_r;
  logic [P_W-1:0]             prod_r, d2_r;
  logic [C_W-1:0]             d25_r;

  logic                       start, win_full;
  logic signed [D_W-1:0]      nx, d_new;
  logic [M_W-1:0]             d_mag, s1_mag, mul_op;
  logic [P_W-1:0]             mul_res, ns2_ext, v;
  logic                       hot, calm, d_pos, d_neg;
  sig_class_t                 cls;
  logic [3:0]                 hit;
  logic [SPREAD_W+SQ_W-1:0]   ram_rdata;
  spread_word_t               old_w;

  rzs_ram #(
    .WIDTH (SPREAD_W + SQ_W),
    .DEPTH (WINDOW)
  ) u_hist (
    .clk     (clk),
    .wr_en   (st_r == ST_FIN),
    .wr_addr (wp_r),
    .wr_data ({x_r, xsq_r}),
    .rd_en   (start),
    .rd_addr (wp_r),
    .rd_data (ram_rdata)
  );

  assign old_w = spread_word_t'(ram_rdata);

  assign start    = (st_r == ST_IDLE) && !q_empty && !res_full;
  assign q_pop    = start;
  assign win_full = (fill_r == N_F);

  // d = n*x - s1
  assign nx    = D_W'(q_word.spread) * N_D;
  assign d_new = nx - D_W'(s1_r);

  assign d_mag   = d_r[D_W-1] ? M_W'(-d_r) : M_W'(d_r);
  assign s1_mag  = s1_r[S1_W-1] ? M_W'(-s1_r) : M_W'(s1_r);
  assign mul_op  = (st_r == ST_SQ_S1) ? s1_mag : d_mag;
  assign mul_res = P_W'(mul_op) * P_W'(mul_op);

  // v = n*s2 - s1^2, clamped at zero
  assign ns2_ext = P_W'(ns2_r);
  assign v       = (ns2_ext < prod_r) ? '0 : ns2_ext - prod_r;
  assign hot     = v < d2_r;
  assign calm    = d25_r < (C_W'(v) << 4);
  assign d_neg   = d_r[D_W-1];
  assign d_pos   = !d_r[D_W-1] && (d_r != '0);

  always_comb begin
    if (!win_full) begin
      cls = CLS_WARMUP;
    end else if (d_pos && hot) begin
      cls = CLS_LONG;
    end else if (d_neg && hot) begin
      cls = CLS_SHORT;
    end else if (calm) begin
      cls = CLS_CLOSE;
    end else begin
      cls = CLS_NONE;
    end
  end

  assign hit = {cls == CLS_NONE, cls == CLS_CLOSE, cls == CLS_SHORT, cls == CLS_LONG};

  always_comb begin
    st_nxt   = st_r;
    s1_nxt   = s1_r;
    s2_nxt   = s2_r;
    wp_nxt   = wp_r;
    fill_nxt = fill_r;
    for (int k = 0; k < 4; k++) begin
      cnt_nxt[k] = cnt_r[k];
    end
    case (st_r)
      ST_IDLE: begin
        if (start) begin
          st_nxt = ST_SQ_D;
        end
      end
      ST_SQ_D: begin
        st_nxt = ST_SQ_S1;
      end
      ST_SQ_S1: begin
        st_nxt = ST_FIN;
      end
      ST_FIN: begin
        st_nxt = ST_IDLE;
        if (win_full) begin
          s1_nxt = s1_r + S1_W'(x_r) - S1_W'(old_w.spread);
          s2_nxt = s2_r + S2_W'(xsq_r) - S2_W'(old_w.square);
          for (int k = 0; k < 4; k++) begin
            if (hit[k] && (cnt_r[k] != '1)) begin
              cnt_nxt[k] = cnt_r[k] + 1'b1;
            end
          end
        end else begin
          s1_nxt   = s1_r + S1_W'(x_r);
          s2_nxt   = s2_r + S2_W'(xsq_r);
          fill_nxt = fill_r + 1'b1;
        end
        wp_nxt = (wp_r == WP_LAST) ? '0 : wp_r + 1'b1;
      end
      default: begin
        st_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r   <= ST_IDLE;
      s1_r   <= '0;
      s2_r   <= '0;
      wp_r   <= '0;
      fill_r <= '0;
      for (int k = 0; k < 4; k++) begin
        cnt_r[k] <= '0;
      end
    end else begin
      st_r   <= st_nxt;
      s1_r   <= s1_nxt;
      s2_r   <= s2_nxt;
      wp_r   <= wp_nxt;
      fill_r <= fill_nxt;
      for (int k = 0; k < 4; k++) begin
        cnt_r[k] <= cnt_nxt[k];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      x_r   <= q_word.spread;
      xsq_r <= q_word.square;
      d_r   <= d_new;
      ns2_r <= NS2_W'(s2_r) * N_S2;
    end
    if (st_r == ST_SQ_D || st_r == ST_SQ_S1) begin
      prod_r <= mul_res;
    end
    if (st_r == ST_SQ_S1) begin
      d2_r  <= prod_r;
      d25_r <= (C_W'(prod_r) << 4) + (C_W'(prod_r) << 3) + C_W'(prod_r);
    end
  end

  assign res_push           = (st_r == ST_FIN);
  assign res_word.cls       = cls;
  assign res_word.long_cnt  = cnt_nxt[0];
  assign res_word.short_cnt = cnt_nxt[1];
  assign res_word.close_cnt = cnt_nxt[2];
  assign res_word.none_cnt  = cnt_nxt[3];

`ifndef SYNTHESIS
  a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
    fill_r <= N_F)
    else $error("fill level beyond window");

  a_wp_bound: assert property (@(posedge clk) disable iff (!rst_n)
    wp_r <= WP_LAST)
    else $error("write pointer beyond window");

  a_res_room: assert property (@(posedge clk) disable iff (!rst_n)
    res_push |-> !res_full)
    else $error("result word pushed into full queue");

  a_long_mono: assert property (@(posedge clk) disable iff (!rst_n)
    $past(rst_n) |-> cnt_r[0] >= $past(cnt_r[0]))
    else $error("long counter went down");

  a_warm_class: assert property (@(posedge clk) disable iff (!rst_n)
    (res_push && !win_full) |=> $stable(cnt_r[3]) && $stable(cnt_r[0]))
    else $error("warm-up word changed a counter");
`endif

endmodule

@@ hdl/rolling_zscore_spread_classifier.sv @@
// top level of the rolling z-score spread classifier
// depends on rzs_pkg, rzs_front, rzs_fifo, rzs_back
//
//  channel | direction | handshake   | word
//  --------+-----------+-------------+--------------------------------------------
//  input   | in        | push / full | in_price_first, in_price_second
//  result  | out       | pop / empty | out_signal_class, out_long/short/close/none_count
//
// the back-end sequencer takes each word through load and form d, square d, square
// the window sum, then score and update before it takes the next word; one squaring
// multiplier is shared by both squaring steps
// synchronous active-low reset clears all control state; no clearing pass is needed
// a stalled result side holds the back end once the two-word result queue is full

module rolling_zscore_spread_classifier
  import rzs_pkg::*;
#(
  parameter int WINDOW = 8
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               push,
  output logic               full,
  input  logic [PRICE_W-1:0] in_price_first,
  input  logic [PRICE_W-1:0] in_price_second,
  output logic               empty,
  input  logic               pop,
  output logic [CLASS_W-1:0] out_signal_class,
  output logic [CNT_W-1:0]   out_long_count,
  output logic [CNT_W-1:0]   out_short_count,
  output logic [CNT_W-1:0]   out_close_count,
  output logic [CNT_W-1:0]   out_none_count
);

  logic                       sq_push, sq_full, sq_pop, sq_empty;
  spread_word_t               sq_wr, sq_rd;
  logic [$bits(spread_word_t)-1:0] sq_rd_raw;
  logic                       rq_push, rq_full;
  result_word_t               rq_wr, rq_rd;
  logic [$bits(result_word_t)-1:0] rq_rd_raw;

  rzs_front u_front (
    .clk          (clk),
    .rst_n        (rst_n),
    .push         (push),
    .full         (full),
    .price_first  (in_price_first),
    .price_second (in_price_second),
    .q_full       (sq_full),
    .q_push       (sq_push),
    .q_word       (sq_wr)
  );

  rzs_fifo #(
    .WIDTH ($bits(spread_word_t)),
    .DEPTH (2)
  ) u_spread_q (
    .clk     (clk),
    .rst_n   (rst_n),
    .push    (sq_push),
    .wr_data (sq_wr),
    .full    (sq_full),
    .pop     (sq_pop),
    .rd_data (sq_rd_raw),
    .empty   (sq_empty)
  );

  assign sq_rd = spread_word_t'(sq_rd_raw);

  rzs_back #(
    .WINDOW (WINDOW)
  ) u_back (
    .clk      (clk),
    .rst_n    (rst_n),
    .q_empty  (sq_empty),
    .q_pop    (sq_pop),
    .q_word   (sq_rd),
    .res_full (rq_full),
    .res_push (rq_push),
    .res_word (rq_wr)
  );

  rzs_fifo #(
    .WIDTH ($bits(result_word_t)),
    .DEPTH (2)
  ) u_result_q (
    .clk     (clk),
    .rst_n   (rst_n),
    .push    (rq_push),
    .wr_data (rq_wr),
    .full    (rq_full),
    .pop     (pop),
    .rd_data (rq_rd_raw),
    .empty   (empty)
  );

  assign rq_rd            = result_word_t'(rq_rd_raw);
  assign out_signal_class = rq_rd.cls;
  assign out_long_count   = rq_rd.long_cnt;
  assign out_short_count  = rq_rd.short_cnt;
  assign out_close_count  = rq_rd.close_cnt;
  assign out_none_count   = rq_rd.none_cnt;

endmodule

@@ tb/testbench.sv @@
// testbench for rolling_zscore_spread_classifier: directed and random price pairs
// checked one word at a time against a built-in predictor of class and counters
// depends on rzs_pkg and the rolling_zscore_spread_classifier rtl
`timescale 1ns / 1ps

module testbench
  import rzs_pkg::*;
();

  localparam int WINDOW      = 8;
  localparam int PRICE_MAX   = 16777215;
  localparam int CYCLE_LIMIT = 400000;
  localparam int SETTLE      = 32;

  typedef struct packed {
    sig_class_t               cls;
    logic [3:0][CNT_W-1:0]    tally;
  } signal_word_t;

  class zscore_checker;
    logic signed [SPREAD_W-1:0] spread_ring [WINDOW];
    longint                     window_total;
    logic [63:0]                window_sq_total;
    int unsigned                ring_idx;
    int unsigned                ring_fill;
    logic [CNT_W-1:0]           tally [4];
    signal_word_t               expected_signals [$];
    int unsigned                error_count;
    int unsigned                reported;

    function void clear();
      window_total    = 0;
      window_sq_total = '0;
      ring_idx        = 0;
      ring_fill       = 0;
      error_count     = 0;
      reported        = 0;
      for (int k = 0; k < 4; k++) tally[k] = '0;
      expected_signals.delete();
    endfunction

    // once the window is full, score the spread against it; then slide or fill the window
    function void note_prices(logic [PRICE_W-1:0] first, logic [PRICE_W-1:0] second);
      logic signed [SPREAD_W-1:0] spread;
      longint                     spread_l;
      longint                     dev;
      longint                     old_l;
      logic [127:0]               dev_abs;
      logic [127:0]               sum_abs;
      logic [127:0]               dev_sq;
      logic [127:0]               scaled_sq;
      logic [127:0]               sum_sq;
      logic [127:0]               var_t;
      sig_class_t                 cls;
      signal_word_t               w;
      spread   = {1'b0, first} - {1'b0, second};
      spread_l = longint'(spread);
      cls      = CLS_WARMUP;
      if (ring_fill >= WINDOW) begin
        dev       = longint'(WINDOW) * spread_l - window_total;
        dev_abs   = '0;
        sum_abs   = '0;
        dev_abs[63:0] = (dev < 0) ? -dev : dev;
        sum_abs[63:0] = (window_total < 0) ? -window_total : window_total;
        dev_sq    = dev_abs * dev_abs;
        scaled_sq = {64'd0, window_sq_total} * 128'(WINDOW);
        sum_sq    = sum_abs * sum_abs;
        var_t     = (scaled_sq < sum_sq) ? 128'd0 : scaled_sq - sum_sq;
        if (dev > 0 && var_t < dev_sq) begin
          cls = CLS_LONG;
        end else if (dev < 0 && var_t < dev_sq) begin
          cls = CLS_SHORT;
        end else if (dev_sq * 128'd25 < var_t * 128'd16) begin
          cls = CLS_CLOSE;
        end else begin
          cls = CLS_NONE;
        end
        if (tally[int'(cls) - 1] != '1) tally[int'(cls) - 1]++;
        old_l           = longint'(spread_ring[ring_idx]);
        window_total    = window_total - old_l;
        window_sq_total = window_sq_total - 64'(old_l * old_l);
      end else begin
        ring_fill++;
      end
      spread_ring[ring_idx] = spread;
      window_total    = window_total + spread_l;
      window_sq_total = window_sq_total + 64'(spread_l * spread_l);
      ring_idx        = (ring_idx + 1 == WINDOW) ? 0 : ring_idx + 1;
      w.cls = cls;
      for (int k = 0; k < 4; k++) w.tally[k] = tally[k];
      expected_signals = {expected_signals, w};
    endfunction

    function void check_signal(logic [CLASS_W-1:0] cls, logic [CNT_W-1:0] long_cnt,
                               logic [CNT_W-1:0] short_cnt, logic [CNT_W-1:0] close_cnt,
                               logic [CNT_W-1:0] none_cnt);
      signal_word_t w;
      if (expected_signals.size() == 0) begin
        error_count++;
        if (reported < 10) begin
          $display("unexpected word: class %0d counts %0d/%0d/%0d/%0d",
                   cls, long_cnt, short_cnt, close_cnt, none_cnt);
        end
        reported++;
      end else begin
        w = expected_signals.pop_front();
        if (cls !== w.cls || long_cnt !== w.tally[0] || short_cnt !== w.tally[1] ||
            close_cnt !== w.tally[2] || none_cnt !== w.tally[3]) begin
          error_count++;
          if (reported < 10) begin
            $display("mismatch: class exp %0d got %0d", w.cls, cls);
            $display("  counts exp %0d/%0d/%0d/%0d got %0d/%0d/%0d/%0d",
                     w.tally[0], w.tally[1], w.tally[2], w.tally[3],
                     long_cnt, short_cnt, close_cnt, none_cnt);
          end
          reported++;
        end
      end
    endfunction
  endclass

  logic               clk;
  logic               rst_n = 1'b0;
  logic               push = 1'b0;
  logic               full;
  logic [PRICE_W-1:0] in_price_first = '0;
  logic [PRICE_W-1:0] in_price_second = '0;
  logic               empty;
  logic               pop = 1'b0;
  logic [CLASS_W-1:0] out_signal_class;
  logic [CNT_W-1:0]   out_long_count;
  logic [CNT_W-1:0]   out_short_count;
  logic [CNT_W-1:0]   out_close_count;
  logic [CNT_W-1:0]   out_none_count;

  zscore_checker sb;
  int            send_idle_pct = 0;
  int            recv_stall_pct = 0;
  int unsigned   cycle_count = 0;
  int            regime_left = 0;
  int            regime_center = 0;
  int            regime_amp = 0;

  rolling_zscore_spread_classifier #(.WINDOW(WINDOW)) u_top (
    .clk              (clk),
    .rst_n            (rst_n),
    .push             (push),
    .full             (full),
    .in_price_first   (in_price_first),
    .in_price_second  (in_price_second),
    .empty            (empty),
    .pop              (pop),
    .out_signal_class (out_signal_class),
    .out_long_count   (out_long_count),
    .out_short_count  (out_short_count),
    .out_close_count  (out_close_count),
    .out_none_count   (out_none_count)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
  end

  initial begin
    while (cycle_count < CYCLE_LIMIT) @(posedge clk);
    $display("timeout after %0d cycles", cycle_count);
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

  // result side: pop with random stalls, check each accepted word
  initial begin
    forever begin
      @(posedge clk);
      if (rst_n && pop && !empty) begin
        sb.check_signal(out_signal_class, out_long_count, out_short_count,
                        out_close_count, out_none_count);
      end
      pop <= (int'($urandom_range(0, 99)) >= recv_stall_pct);
    end
  end

  task automatic send_prices(input logic [PRICE_W-1:0] first, input logic [PRICE_W-1:0] second);
    in_price_first  <= first;
    in_price_second <= second;
    push            <= 1'b1;
    @(posedge clk);
    while (full) @(posedge clk);
    sb.note_prices(first, second);
  endtask

  task automatic wait_all_signals();
    while (sb.expected_signals.size() != 0) @(posedge clk);
  endtask

  // spreads drawn from regimes of center and noise, with outliers and raw noise
  task automatic pick_prices(output logic [PRICE_W-1:0] first,
                             output logic [PRICE_W-1:0] second);
    int spread;
    int cmax;
    int a;
    if (regime_left == 0) begin
      regime_left = $urandom_range(8, 40);
      case ($urandom_range(0, 2))
        0: cmax = 1000;
        1: cmax = 100000;
        default: cmax = PRICE_MAX;
      endcase
      regime_center = int'($urandom_range(0, 2 * cmax)) - cmax;
      case ($urandom_range(0, 9))
        0: regime_amp = 0;
        1, 2, 3, 4, 5: regime_amp = $urandom_range(1, 200);
        6, 7, 8: regime_amp = $urandom_range(201, 50000);
        default: regime_amp = $urandom_range(50001, 4000000);
      endcase
    end
    regime_left--;
    if ($urandom_range(0, 99) < 12) begin
      first  = PRICE_W'($urandom_range(0, PRICE_MAX));
      second = PRICE_W'($urandom_range(0, PRICE_MAX));
    end else begin
      spread = regime_center + int'($urandom_range(0, 2 * regime_amp)) - regime_amp;
      if ($urandom_range(0, 99) < 12) begin
        a = 3 * regime_amp + int'($urandom_range(1, 1000));
        spread = $urandom_range(0, 1) ? spread + a : spread - a;
      end
      if (spread > PRICE_MAX) spread = PRICE_MAX;
      if (spread < -PRICE_MAX) spread = -PRICE_MAX;
      if (spread >= 0) begin
        a      = $urandom_range(0, PRICE_MAX - spread);
        second = PRICE_W'(a);
        first  = PRICE_W'(a + spread);
      end else begin
        a      = $urandom_range(0, PRICE_MAX + spread);
        first  = PRICE_W'(a);
        second = PRICE_W'(a - spread);
      end
    end
  endtask

  task automatic run_phase(input int count, input int idle_pct, input int stall_pct);
    logic [PRICE_W-1:0] first;
    logic [PRICE_W-1:0] second;
    int                 gap;
    send_idle_pct  = idle_pct;
    recv_stall_pct = stall_pct;
    for (int i = 0; i < count; i++) begin
      gap = 0;
      while (gap < 60 && int'($urandom_range(0, 99)) < send_idle_pct) gap++;
      if (gap > 0) begin
        push <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      pick_prices(first, second);
      send_prices(first, second);
    end
    push <= 1'b0;
    @(posedge clk);
    wait_all_signals();
  endtask

  logic [PRICE_W-1:0] directed_first [22] = '{
    24'd0, 24'hFFFFFF, 24'd5000, 24'd123456, 24'd1, 24'h800000, 24'h7FFFFF, 24'd77,
    24'd1000, 24'hFFFFFF, 24'd0,
    24'd1100, 24'd1000, 24'd1100, 24'd1000, 24'd1100, 24'd1000, 24'd1100, 24'd1000,
    24'd2000, 24'd1000, 24'hAAAAAA
  };
  logic [PRICE_W-1:0] directed_second [22] = '{
    24'd0, 24'hFFFFFF, 24'd5000, 24'd123456, 24'd1, 24'h800000, 24'h7FFFFF, 24'd77,
    24'd1000, 24'd0, 24'hFFFFFF,
    24'd1000, 24'd1100, 24'd1000, 24'd1100, 24'd1000, 24'd1100, 24'd1000, 24'd1100,
    24'd2000, 24'd1100, 24'h555555
  };

  initial begin
    sb = new;
    sb.clear();
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;

    // warm-up on a flat spread, zero deviation, both extremes, then a close
    for (int i = 0; i < 22; i++) send_prices(directed_first[i], directed_second[i]);
    push <= 1'b0;
    @(posedge clk);
    wait_all_signals();

    run_phase(150, 0, 0);
    run_phase(200, 71, 0);
    run_phase(200, 0, 71);
    run_phase(200, 13, 13);
    run_phase(100, 0, 0);
    run_phase(100, 13, 13);

    wait_all_signals();
    repeat (SETTLE) @(posedge clk);
    if (sb.expected_signals.size() != 0) begin
      sb.error_count++;
      $display("%0d expected words never arrived", sb.expected_signals.size());
    end
    if (sb.error_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule

@@ rolling_zscore_spread_classifier.f @@
hdl/rzs_pkg.sv
hdl/rzs_ram.sv
hdl/rzs_fifo.sv
hdl/rzs_front.sv
hdl/rzs_back.sv
hdl/rolling_zscore_spread_classifier.sv
tb/testbench.sv
